@@ sv/whp_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the 802.11 MAC header tagger.
// Used by the front end, the queue, the back end and the checker.
package whp_pkg;

    // Frame type codes (frame control bits 3:2)
    localparam logic [1:0] TYPE_MGMT = 2'd0;
    localparam logic [1:0] TYPE_CTRL = 2'd1;
    localparam logic [1:0] TYPE_DATA = 2'd2;
    localparam logic [1:0] TYPE_RSVD = 2'd3;

    // Control frame subtypes
    localparam logic [3:0] SUB_BAR         = 4'h8;
    localparam logic [3:0] SUB_BA          = 4'h9;
    localparam logic [3:0] SUB_PS_POLL     = 4'ha;
    localparam logic [3:0] SUB_RTS         = 4'hb;
    localparam logic [3:0] SUB_CTS         = 4'hc;
    localparam logic [3:0] SUB_ACK         = 4'hd;
    localparam logic [3:0] SUB_CF_END      = 4'he;
    localparam logic [3:0] SUB_CF_END_ACK  = 4'hf;

    // Field tags
    localparam logic [3:0] TAG_FC      = 4'd0;
    localparam logic [3:0] TAG_DUR     = 4'd1;
    localparam logic [3:0] TAG_A1      = 4'd2;
    localparam logic [3:0] TAG_A2      = 4'd3;
    localparam logic [3:0] TAG_A3      = 4'd4;
    localparam logic [3:0] TAG_SEQ     = 4'd5;
    localparam logic [3:0] TAG_A4      = 4'd6;
    localparam logic [3:0] TAG_QOS     = 4'd7;
    localparam logic [3:0] TAG_HT      = 4'd8;
    localparam logic [3:0] TAG_BAR     = 4'd9;
    localparam logic [3:0] TAG_PAYLOAD = 4'd10;
    localparam logic [3:0] TAG_OTHER   = 4'd11;

    // Byte position counter
    localparam int          POS_W   = 6;
    localparam logic [5:0]  POS_MAX = 6'd63;

    // Start positions of the fixed header fields, the end of the BAR field and field lengths
    localparam logic [5:0] START_DUR = 6'd2;
    localparam logic [5:0] START_A1  = 6'd4;
    localparam logic [5:0] START_A2  = 6'd10;
    localparam logic [5:0] START_A3  = 6'd16;
    localparam logic [5:0] START_BAR = 6'd16;
    localparam logic [5:0] START_SEQ = 6'd22;
    localparam logic [5:0] START_VAR = 6'd24;
    localparam logic [5:0] END_BAR   = 6'd18;
    localparam logic [5:0] LEN_ADDR  = 6'd6;
    localparam logic [5:0] LEN_QOS   = 6'd2;
    localparam logic [5:0] LEN_HT    = 6'd4;

    // Queue between front and back end (power of two, at least 2)
    localparam int QUEUE_DEPTH = 2;

    // One queued transaction: the byte plus its classification context
    typedef struct packed {
        logic [7:0]       data;
        logic             last;
        logic [POS_W-1:0] pos;
        logic [7:0]       cb0;
        logic [7:0]       cb1;
    } whp_entry_t;

endpackage

@@ sv/whp_front.sv @@
`timescale 1ns / 1ps
// Front end: accepts frame bytes, tracks the byte position and latches
// the two frame control bytes. Depends on whp_pkg.
module whp_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               src_valid,
    input  logic [7:0]         data_byte,
    input  logic               last_byte,
    input  logic               queue_full,
    output logic               push,
    output whp_pkg::whp_entry_t push_entry
);
    import whp_pkg::*;

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [7:0]       cb0_reg, cb0_next;
    logic [7:0]       cb1_reg, cb1_next;

    // Accept whenever the queue has room
    assign push = src_valid && !queue_full;

    // Latch frame control on the first two bytes
    always_comb
    begin
        cb0_next = cb0_reg;
        cb1_next = cb1_reg;
        if (pos_reg == '0)
        begin
            cb0_next = data_byte;
            cb1_next = '0;
        end
        else if (pos_reg == POS_W'(1))
        begin
            cb1_next = data_byte;
        end
    end

    // Advance position, saturate, restart after the last byte
    always_comb
    begin
        if (last_byte)
            pos_next = '0;
        else if (pos_reg < POS_MAX)
            pos_next = pos_reg + POS_W'(1);
        else
            pos_next = pos_reg;
    end

    assign push_entry = '{data: data_byte, last: last_byte, pos: pos_reg,
                          cb0: cb0_next, cb1: cb1_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            cb0_reg <= '0;
            cb1_reg <= '0;
        end
        else if (push)
        begin
            pos_reg <= pos_next;
            cb0_reg <= cb0_next;
            cb1_reg <= cb1_next;
        end
    end

endmodule

@@ sv/whp_queue.sv @@
`timescale 1ns / 1ps
// Small register queue between the front and back end.
// Depends on whp_pkg for the entry type.
module whp_queue #(
    parameter int DEPTH = whp_pkg::QUEUE_DEPTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  whp_pkg::whp_entry_t push_entry,
    input  logic               pop,
    output logic               full,
    output logic               not_empty,
    output whp_pkg::whp_entry_t head
);
    import whp_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    whp_entry_t       slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = slot_reg[rd_ptr_reg];

    // Track occupancy
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
        end
    end

    // Store payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_entry;
    end

endmodule

@@ sv/whp_back.sv @@
`timescale 1ns / 1ps
// Back end: tags the queued byte with its header field and offset and
// holds the result in the output register. Depends on whp_pkg.
module whp_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               head_valid,
    input  whp_pkg::whp_entry_t head,
    output logic               pop,
    output logic               res_valid,
    input  logic               res_stall,
    output logic [7:0]         byte_out,
    output logic [3:0]         field_tag,
    output logic [2:0]         offset_in_field,
    output logic [1:0]         frame_type,
    output logic [3:0]         frame_subtype,
    output logic               to_ds_flag,
    output logic               from_ds_flag,
    output logic               protected_flag,
    output logic               order_flag,
    output logic               end_of_frame
);
    import whp_pkg::*;

    logic       valid_reg;
    logic [7:0] byte_reg;
    logic [3:0] tag_reg, tag_next;
    logic [2:0] off_reg, off_next;
    logic [7:0] cb0_reg;
    logic [7:0] cb1_reg;
    logic       last_reg;

    logic [1:0] ftype;
    logic [3:0] fsub;
    logic [5:0] pos;
    logic [5:0] start;
    logic [5:0] diff;
    logic       hit;

    assign ftype = head.cb0[3:2];
    assign fsub  = head.cb0[7:4];
    assign pos   = head.pos;

    // Take the head when the output register is free or being drained
    assign pop = head_valid && (!valid_reg || !res_stall);

    // Classify the byte position against the frame layout
    always_comb
    begin
        tag_next = TAG_OTHER;
        start    = '0;
        hit      = 1'b0;
        diff     = '0;
        if (ftype == TYPE_MGMT || ftype == TYPE_DATA)
        begin
            if (pos < START_DUR)
            begin
                tag_next = TAG_FC;    start = '0;
            end
            else if (pos < START_A1)
            begin
                tag_next = TAG_DUR;   start = START_DUR;
            end
            else if (pos < START_A2)
            begin
                tag_next = TAG_A1;    start = START_A1;
            end
            else if (pos < START_A3)
            begin
                tag_next = TAG_A2;    start = START_A2;
            end
            else if (pos < START_SEQ)
            begin
                tag_next = TAG_A3;    start = START_A3;
            end
            else if (pos < START_VAR)
            begin
                tag_next = TAG_SEQ;   start = START_SEQ;
            end
            else
            begin
                // Optional fields follow one another from byte 24
                tag_next = TAG_PAYLOAD;
                start    = START_VAR;
                if (ftype == TYPE_DATA && head.cb1[0] && head.cb1[1])
                begin
                    if (pos < start + LEN_ADDR)
                    begin
                        tag_next = TAG_A4;
                        hit      = 1'b1;
                    end
                    else
                        start = start + LEN_ADDR;
                end
                if (!hit && ftype == TYPE_DATA && fsub[3])
                begin
                    if (pos < start + LEN_QOS)
                    begin
                        tag_next = TAG_QOS;
                        hit      = 1'b1;
                    end
                    else
                        start = start + LEN_QOS;
                end
                if (!hit && head.cb1[7])
                begin
                    if (pos < start + LEN_HT)
                    begin
                        tag_next = TAG_HT;
                        hit      = 1'b1;
                    end
                end
            end
        end
        else if (ftype == TYPE_CTRL)
        begin
            unique case (fsub) inside
                SUB_RTS, SUB_PS_POLL, SUB_CF_END, SUB_CF_END_ACK,
                SUB_CTS, SUB_ACK, SUB_BAR, SUB_BA:
                begin
                    if (pos < START_DUR)
                    begin
                        tag_next = TAG_FC;   start = '0;
                    end
                    else if (pos < START_A1)
                    begin
                        tag_next = TAG_DUR;  start = START_DUR;
                    end
                    else if (pos < START_A2)
                    begin
                        tag_next = TAG_A1;   start = START_A1;
                    end
                    else if (pos < START_A3 && fsub != SUB_CTS && fsub != SUB_ACK)
                    begin
                        tag_next = TAG_A2;   start = START_A2;
                    end
                    else if (pos < END_BAR && (fsub == SUB_BAR || fsub == SUB_BA))
                    begin
                        tag_next = TAG_BAR;  start = START_BAR;
                    end
                    else if (fsub == SUB_BAR || fsub == SUB_BA)
                        tag_next = TAG_PAYLOAD;
                    else
                        tag_next = TAG_OTHER;
                end
                default:
                    tag_next = TAG_OTHER;
            endcase
        end
        diff = pos - start;
        if (tag_next == TAG_PAYLOAD || tag_next == TAG_OTHER)
            off_next = '0;
        else
            off_next = diff[2:0];
    end

    // Hold the result until the receiver takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (pop)
            valid_reg <= 1'b1;
        else if (!res_stall)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            byte_reg <= head.data;
            tag_reg  <= tag_next;
            off_reg  <= off_next;
            cb0_reg  <= head.cb0;
            cb1_reg  <= head.cb1;
            last_reg <= head.last;
        end
    end

    assign res_valid       = valid_reg;
    assign byte_out        = byte_reg;
    assign field_tag       = tag_reg;
    assign offset_in_field = off_reg;
    assign frame_type      = cb0_reg[3:2];
    assign frame_subtype   = cb0_reg[7:4];
    assign to_ds_flag      = cb1_reg[0];
    assign from_ds_flag    = cb1_reg[1];
    assign protected_flag  = cb1_reg[6];
    assign order_flag      = cb1_reg[7];
    assign end_of_frame    = last_reg;

endmodule

@@ sv/wlan_mac_header_parser_core.sv @@
`timescale 1ns / 1ps
// 802.11 MAC header field tagger, one frame byte per cycle while not stalled.
//
// Input channel: data_byte with last_byte marking the final byte of a frame,
// handshaken by src_valid / src_stall. Output channel: the byte passed through
// with its field tag, offset inside the field, frame type and subtype and the
// frame control flags, handshaken by res_valid / res_stall.
// Each input transaction yields exactly one output transaction, in order.
// An accepted byte is written into a queue slot and then taken into the output
// register, which drives the output ports.
// Throughput: one byte per cycle while res_stall is low; the front end, the
// queue and the output register each move one transaction per cycle.
// The front end latches frame control and counts bytes; the back end tags
// the byte and holds the result. A QUEUE_DEPTH-entry queue separates them.
// When the receiver stalls, the output register holds its transaction and the
// queue fills; src_stall rises once the queue is full.
// Reset clears the byte position, the latched frame control bytes, the queue
// and the output valid.
// Depends on whp_pkg, whp_front, whp_queue and whp_back.
module wlan_mac_header_parser_core #(
    parameter int QUEUE_DEPTH = whp_pkg::QUEUE_DEPTH
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       src_valid,
    output logic       src_stall,
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    output logic       res_valid,
    input  logic       res_stall,
    output logic [7:0] byte_out,
    output logic [3:0] field_tag,
    output logic [2:0] offset_in_field,
    output logic [1:0] frame_type,
    output logic [3:0] frame_subtype,
    output logic       to_ds_flag,
    output logic       from_ds_flag,
    output logic       protected_flag,
    output logic       order_flag,
    output logic       end_of_frame
);
    import whp_pkg::*;

    logic       push;
    logic       pop;
    logic       queue_full;
    logic       queue_not_empty;
    whp_entry_t push_entry;
    whp_entry_t head;

    assign src_stall = queue_full;

    whp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .src_valid  (src_valid),
        .data_byte  (data_byte),
        .last_byte  (last_byte),
        .queue_full (queue_full),
        .push       (push),
        .push_entry (push_entry)
    );

    whp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .full       (queue_full),
        .not_empty  (queue_not_empty),
        .head       (head)
    );

    whp_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .head_valid      (queue_not_empty),
        .head            (head),
        .pop             (pop),
        .res_valid       (res_valid),
        .res_stall       (res_stall),
        .byte_out        (byte_out),
        .field_tag       (field_tag),
        .offset_in_field (offset_in_field),
        .frame_type      (frame_type),
        .frame_subtype   (frame_subtype),
        .to_ds_flag      (to_ds_flag),
        .from_ds_flag    (from_ds_flag),
        .protected_flag  (protected_flag),
        .order_flag      (order_flag),
        .end_of_frame    (end_of_frame)
    );

endmodule

@@ sv/whp_checker.sv @@
`timescale 1ns / 1ps
// Port-level checks for the MAC header tagger, bound to the top level.
// Depends on whp_pkg and wlan_mac_header_parser_core.
module whp_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       res_valid,
    input logic       res_stall,
    input logic [7:0] byte_out,
    input logic [3:0] field_tag,
    input logic [2:0] offset_in_field,
    input logic [1:0] frame_type
);
    import whp_pkg::*;

    // Hold a stalled output transaction
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(byte_out) && $stable(field_tag))
        else $error("stalled output transaction changed");

    // Tags stay within the defined set
    a_tag_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> field_tag <= TAG_OTHER)
        else $error("field tag out of range");

    // Payload and other carry no offset
    a_tail_offset: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (field_tag == TAG_PAYLOAD || field_tag == TAG_OTHER)
        |-> offset_in_field == 3'd0)
        else $error("nonzero offset on payload or other byte");

    // Offsets never exceed an address length
    a_offset_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> offset_in_field <= 3'd5)
        else $error("offset beyond longest field");

    // Reserved frames are tagged other throughout
    a_reserved_other: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && frame_type == TYPE_RSVD |-> field_tag == TAG_OTHER)
        else $error("reserved frame byte not tagged other");

endmodule

bind wlan_mac_header_parser_core whp_checker u_whp_checker (.*);
